// ----- src/assert_macros.svh -----
// Shared assertion macros. Each one expects signals named clk and arst_n
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lprt_pkg.sv -----
package lprt_pkg;

	// Default number of route entries.
	localparam int DEFAULT_TABLE_DEPTH = 64;

	// Item action codes.
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_HIT     = 3'd0;
	localparam logic [2:0] STAT_DEFAULT = 3'd1;
	localparam logic [2:0] STAT_NONE    = 3'd2;
	localparam logic [2:0] STAT_ADDED   = 3'd3;
	localparam logic [2:0] STAT_DUP     = 3'd4;
	localparam logic [2:0] STAT_FULL    = 3'd5;
	localparam logic [2:0] STAT_CLEARED = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DEF_VALID = 2'd0;
	localparam logic [1:0] CFG_DEF_IFACE = 2'd1;
	localparam logic [1:0] CFG_DEF_HOP   = 2'd2;

	localparam logic [5:0] MAX_LEN = 6'd32;

	// One stored route, valid flag included.
	typedef struct packed {
		logic        valid;
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [7:0]  iface;
		logic [31:0] hop;
	} route_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the accepted item
		logic scan;     // read the entry at the index this cycle
		logic clr_wr;   // write an empty entry at the index
		logic out_load; // load the result register and commit an insert
	} lprt_cmd_t;

	// Network mask of the given length; lengths above 32 give all ones.
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	// Prefix length clamped to 32.
	function automatic logic [5:0] sat_len(input logic [5:0] len);
		return (len > MAX_LEN) ? MAX_LEN : len;
	endfunction

endpackage

// ----- src/lprt_ram.sv -----
module lprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/lprt_ctrl.sv -----
`include "assert_macros.svh"

module lprt_ctrl #(
	parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lprt_pkg::lprt_cmd_t            cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0] idx
);
	import lprt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_LAST  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic          out_valid_q;
	logic          in_xfer;
	logic          out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign idx       = cnt_q;

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.load     = in_xfer;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.clr_wr   = (state_q == ST_CLEAR) || (state_q == ST_INIT);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	// Sequencer: clearing sweeps and table scans step the index once a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						case (action) inside
							ACT_LOOKUP, ACT_ADD: state_q <= ST_SCAN;
							ACT_CLEAR:           state_q <= ST_CLEAR;
							default:             state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Result register occupancy: set on load, cleared on an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !out_valid_q || !out_stall, "result overwritten")
	`ASSERT_NEXT(a_busy_after_accept, in_xfer, in_stall, "input taken while busy")
	`ASSERT_NEXT(a_scan_from_zero, in_xfer, cnt_q == '0, "scan does not start at entry zero")
	`ASSERT_IMPLIES(a_no_write_in_scan, cmd.scan, !cmd.clr_wr, "clear write during a scan")

endmodule

// ----- src/lprt_dp.sv -----
module lprt_dp #(
	parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lprt_pkg::lprt_cmd_t            cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
	input  logic [1:0]                     action,
	input  logic [31:0]                    address,
	input  logic [5:0]                     prefix_len,
	input  logic [7:0]                     iface,
	input  logic [31:0]                    next_hop,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic [2:0]                     status,
	output logic [7:0]                     out_iface,
	output logic [31:0]                    out_next_hop,
	output logic [5:0]                     matched_len
);
	import lprt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int EW = $bits(route_entry_t);

	// Configuration registers.
	logic        def_valid_q;
	logic [7:0]  def_iface_q;
	logic [31:0] def_hop_q;

	// Captured item.
	logic [1:0]  action_q;
	logic [31:0] addr_q;
	logic [31:0] pfx_q;
	logic [5:0]  plen_q;
	logic [7:0]  iface_q;
	logic [31:0] hop_q;

	// Scan results.
	logic          found_q;
	logic [5:0]    best_len_q;
	logic [7:0]    best_iface_q;
	logic [31:0]   best_hop_q;
	logic          dup_q;
	logic          free_ok_q;
	logic [AW-1:0] free_q;

	// Read pipeline.
	logic          eval_s1;
	logic [AW-1:0] idx_s1;

	route_entry_t  rd_entry;
	route_entry_t  wr_entry;
	logic [EW-1:0] rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          insert;
	logic          match;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_valid_q <= 1'b0;
			def_iface_q <= '0;
			def_hop_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEF_VALID: def_valid_q <= cfg_data[0];
				CFG_DEF_IFACE: def_iface_q <= cfg_data[7:0];
				CFG_DEF_HOP:   def_hop_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture, with the added prefix masked to its clamped length.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			addr_q   <= address;
			plen_q   <= sat_len(prefix_len);
			pfx_q    <= address & len_mask(prefix_len);
			iface_q  <= iface;
			hop_q    <= next_hop;
		end
	end

	// A new insert goes to the first free entry once the scan found no duplicate.
	assign insert = cmd.out_load && (action_q == ACT_ADD) && !dup_q && free_ok_q;

	always_comb begin
		wr_entry        = '0;
		wr_entry.valid  = 1'b1;
		wr_entry.prefix = pfx_q;
		wr_entry.len    = plen_q;
		wr_entry.iface  = iface_q;
		wr_entry.hop    = hop_q;
		if (cmd.clr_wr) begin
			wr_entry = '0;
		end
	end

	assign ram_we    = cmd.clr_wr || insert;
	assign ram_waddr = cmd.clr_wr ? idx : free_q;

	lprt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.raddr(idx),
		.rdata(rdata)
	);

	assign rd_entry = route_entry_t'(rdata);

	// Read data arrives in the cycle after the address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	assign match = ((addr_q & len_mask(rd_entry.len)) == rd_entry.prefix);

	// Per-entry evaluation: longest match, duplicate check and first free entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			dup_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd.load) begin
			found_q   <= 1'b0;
			dup_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (eval_s1) begin
			if (rd_entry.valid) begin
				if (match && (!found_q || (rd_entry.len > best_len_q))) begin
					found_q <= 1'b1;
				end
				if ((rd_entry.len == plen_q) && (rd_entry.prefix == pfx_q)) begin
					dup_q <= 1'b1;
				end
			end else begin
				free_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_s1) begin
			if (rd_entry.valid && match && (!found_q || (rd_entry.len > best_len_q))) begin
				best_len_q   <= rd_entry.len;
				best_iface_q <= rd_entry.iface;
				best_hop_q   <= rd_entry.hop;
			end
			if (!rd_entry.valid && !free_ok_q) begin
				free_q <= idx_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_iface    <= '0;
			out_next_hop <= '0;
			matched_len  <= '0;
			case (action_q)
				ACT_LOOKUP: begin
					if (found_q) begin
						status       <= STAT_HIT;
						out_iface    <= best_iface_q;
						out_next_hop <= best_hop_q;
						matched_len  <= best_len_q;
					end else if (def_valid_q) begin
						status       <= STAT_DEFAULT;
						out_iface    <= def_iface_q;
						out_next_hop <= def_hop_q;
					end else begin
						status <= STAT_NONE;
					end
				end
				ACT_ADD: begin
					if (dup_q) begin
						status <= STAT_DUP;
					end else if (!free_ok_q) begin
						status <= STAT_FULL;
					end else begin
						status <= STAT_ADDED;
					end
				end
				ACT_CLEAR: status <= STAT_CLEARED;
				default:   status <= STAT_NONE;
			endcase
		end
	end

endmodule

// ----- src/longest_prefix_route_table_unit.sv -----
// Lookup and add: after the input transfer every entry is scanned through the
// single read port of the route memory, then the result register is loaded.
// Clear writes an empty entry at every index first; an unknown action goes
// straight to the result. A new item is taken only once the last result is loaded.
// Reset: a clearing pass over all entries runs first, with in_stall high;
// configuration registers reset to zero.
module longest_prefix_route_table_unit #(
	parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic [7:0]  iface,
	input  logic [31:0] next_hop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  out_iface,
	output logic [31:0] out_next_hop,
	output logic [5:0]  matched_len,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lprt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	lprt_cmd_t     cmd;
	logic [AW-1:0] idx;

	// Sequencing and handshakes.
	lprt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.idx      (idx)
	);

	// Route memory, scan evaluation and result register.
	lprt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.action      (action),
		.address     (address),
		.prefix_len  (prefix_len),
		.iface       (iface),
		.next_hop    (next_hop),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.out_iface   (out_iface),
		.out_next_hop(out_next_hop),
		.matched_len (matched_len)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	import lprt_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SEGMENT_ITEMS = 285;
	localparam int SEGMENTS = 6;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [7:0]  iface;
		logic [31:0] next_hop;
	} route_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  iface;
		logic [31:0] next_hop;
		logic [5:0]  matched_len;
	} route_reply_t;

	typedef struct {
		logic [31:0] addr;
		logic [5:0]  len;
	} known_route_t;

	// Mirror of the route table and default route; it predicts the reply to
	// every accepted request and compares it with what the block returns.
	class route_table_mirror;
		bit          slot_used [TABLE_DEPTH];
		logic [31:0] slot_prefix [TABLE_DEPTH];
		logic [5:0]  slot_len [TABLE_DEPTH];
		logic [7:0]  slot_iface [TABLE_DEPTH];
		logic [31:0] slot_hop [TABLE_DEPTH];
		logic        def_valid;
		logic [7:0]  def_iface;
		logic [31:0] def_hop;
		route_reply_t awaited_replies [$];
		int fault_count;

		function new();
			foreach (slot_used[k]) begin
				slot_used[k] = 1'b0;
			end
			def_valid = 1'b0;
			def_iface = 8'h00;
			def_hop = 32'h0;
			fault_count = 0;
		endfunction

		// Leading-ones mask; lengths of 32 and above give all ones.
		static function logic [31:0] mask_of(logic [5:0] len);
			if (len == 6'd0)
				return 32'h0;
			if (len >= MAX_LEN)
				return 32'hFFFF_FFFF;
			return 32'hFFFF_FFFF << (32 - len);
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_DEF_VALID: def_valid = data[0];
				CFG_DEF_IFACE: def_iface = data[7:0];
				CFG_DEF_HOP:   def_hop = data;
				default: ;
			endcase
		endfunction

		// Works out the reply to one request and applies its effect on the table.
		function route_reply_t route_answer(route_req_t req);
			route_reply_t ans;
			logic [5:0]  len;
			logic [31:0] pfx;
			int best;
			int free_slot;
			bit dup;
			ans = '0;
			len = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;
			case (req.action)
				ACT_LOOKUP: begin
					best = -1;
					for (int k = 0; k < TABLE_DEPTH; k++) begin
						if (slot_used[k] && (req.address & mask_of(slot_len[k])) == slot_prefix[k]
								&& (best < 0 || slot_len[k] > slot_len[best]))
							best = k;
					end
					if (best >= 0)
						ans = route_reply_t'{STAT_HIT, slot_iface[best], slot_hop[best],
							slot_len[best]};
					else if (def_valid)
						ans = route_reply_t'{STAT_DEFAULT, def_iface, def_hop, 6'd0};
					else
						ans.status = STAT_NONE;
				end
				ACT_ADD: begin
					pfx = req.address & mask_of(len);
					free_slot = -1;
					dup = 1'b0;
					for (int k = 0; k < TABLE_DEPTH; k++) begin
						if (slot_used[k]) begin
							if (slot_len[k] == len && slot_prefix[k] == pfx)
								dup = 1'b1;
						end else if (free_slot < 0) begin
							free_slot = k;
						end
					end
					if (dup) begin
						ans.status = STAT_DUP;
					end else if (free_slot < 0) begin
						ans.status = STAT_FULL;
					end else begin
						slot_used[free_slot] = 1'b1;
						slot_prefix[free_slot] = pfx;
						slot_len[free_slot] = len;
						slot_iface[free_slot] = req.iface;
						slot_hop[free_slot] = req.next_hop;
						ans.status = STAT_ADDED;
					end
				end
				ACT_CLEAR: begin
					foreach (slot_used[k]) begin
						slot_used[k] = 1'b0;
					end
					ans.status = STAT_CLEARED;
				end
				default: ans.status = STAT_NONE;
			endcase
			return ans;
		endfunction

		function void take_request(route_req_t req);
			awaited_replies.push_back(route_answer(req));
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] seen);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
			fault_count++;
		endfunction

		function void match_reply(route_reply_t got);
			route_reply_t want;
			if (awaited_replies.size() == 0) begin
				$display("%0t: reply with no request pending, got status %0d iface %0h hop %0h len %0d",
					$time, got.status, got.iface, got.next_hop, got.matched_len);
				fault_count++;
				return;
			end
			want = awaited_replies.pop_front();
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.iface !== want.iface)
				report("out_iface", 32'(want.iface), 32'(got.iface));
			if (got.next_hop !== want.next_hop)
				report("out_next_hop", want.next_hop, got.next_hop);
			if (got.matched_len !== want.matched_len)
				report("matched_len", 32'(want.matched_len), 32'(got.matched_len));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_LOOKUP;
	logic [31:0] address = 32'h0;
	logic [5:0]  prefix_len = 6'd0;
	logic [7:0]  iface = 8'h00;
	logic [31:0] next_hop = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  out_iface;
	logic [31:0] out_next_hop;
	logic [5:0]  matched_len;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DEF_VALID;
	logic [31:0] cfg_data = 32'h0;

	int send_idle_pct = 23;
	int recv_stall_pct = 74;

	route_table_mirror mirror = new();
	known_route_t known_routes [$];

	longest_prefix_route_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.address(address),
		.prefix_len(prefix_len),
		.iface(iface),
		.next_hop(next_hop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_iface(out_iface),
		.out_next_hop(out_next_hop),
		.matched_len(matched_len),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	// Reply side: check each result transfer, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.match_reply(route_reply_t'{status, out_iface, out_next_hop, matched_len});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Present one request, possibly after a gap, and wait for its transfer.
	task automatic send_request(input route_req_t req);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, TABLE_DEPTH + 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= req.action;
		address <= req.address;
		prefix_len <= req.prefix_len;
		iface <= req.iface;
		next_hop <= req.next_hop;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mirror.take_request(req);
	endtask

	// Stop sending and let every outstanding reply come back.
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (mirror.awaited_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the default route registers, plus the unused index, which must
	// be ignored. Bits above each register's width carry random values.
	task automatic apply_default(input logic valid_bit, input logic [7:0] ifc,
			input logic [31:0] hop);
		logic [1:0]  regs [4];
		logic [31:0] words [4];
		regs = '{CFG_DEF_VALID, CFG_DEF_IFACE, CFG_DEF_HOP, CFG_UNUSED};
		words[0] = ($urandom & 32'hFFFF_FFFE) | {31'd0, valid_bit};
		words[1] = ($urandom & 32'hFFFF_FF00) | {24'd0, ifc};
		words[2] = hop;
		words[3] = $urandom;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= words[i];
			@(posedge clk);
			mirror.write_reg(regs[i], words[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Random request; half of the adds and most lookups reuse or nest under routes
	// already offered, so hits, duplicates and a full table all occur.
	function automatic route_req_t random_request();
		route_req_t req;
		known_route_t pick;
		logic [31:0] m;
		int roll;
		req.action = ACT_LOOKUP;
		req.address = $urandom;
		req.prefix_len = 6'($urandom_range(0, 63));
		req.iface = 8'($urandom);
		req.next_hop = $urandom;
		if (known_routes.size() != 0) begin
			pick = known_routes[$urandom_range(known_routes.size() - 1)];
		end else begin
			pick.addr = $urandom;
			pick.len = 6'd16;
		end
		m = route_table_mirror::mask_of(pick.len);
		roll = $urandom_range(999);
		if (roll < 4) begin
			req.action = ACT_CLEAR;
		end else if (roll < 30) begin
			req.action = ACT_UNKNOWN;
		end else if (roll < 460) begin
			req.action = ACT_ADD;
			case ($urandom_range(9))
				// The same route again, with the bits below the prefix changed.
				0, 1: begin
					req.address = (pick.addr & m) | (req.address & ~m);
					req.prefix_len = pick.len;
				end
				// A longer or shorter prefix sharing a known one.
				2, 3, 4: begin
					req.address = (pick.addr & m) | (req.address & ~m);
					req.prefix_len = 6'($urandom_range(0, 32));
				end
				5: req.prefix_len = 6'($urandom_range(33, 63));
				default: req.prefix_len = 6'($urandom_range(0, 32));
			endcase
			pick.addr = req.address;
			pick.len = req.prefix_len;
			known_routes.push_back(pick);
			if (known_routes.size() > 200)
				void'(known_routes.pop_front());
		end else if ($urandom_range(9) < 6) begin
			req.address = (pick.addr & m) | (req.address & ~m);
		end
		return req;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The table is cleared after reset with in_stall held high.
		while (in_stall) @(posedge clk);
		apply_default(1'b0, 8'h00, 32'h0);

		// Directed part: empty table, saturation, duplicates, nesting, /0, /32.
		send_request(route_req_t'{ACT_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_UNKNOWN, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF});
		send_request(route_req_t'{ACT_ADD, 32'h0A01_0203, 6'd8, 8'h01, 32'h0A00_0001});
		send_request(route_req_t'{ACT_ADD, 32'h0A63_0000, 6'd8, 8'h09, 32'h0A00_0009});
		send_request(route_req_t'{ACT_ADD, 32'h0A01_0203, 6'd40, 8'h02, 32'h0A00_0002});
		send_request(route_req_t'{ACT_ADD, 32'h0A01_0203, 6'd32, 8'h0A, 32'h0A00_000A});
		send_request(route_req_t'{ACT_ADD, 32'h0A01_FFFF, 6'd16, 8'h03, 32'h0A00_0003});
		send_request(route_req_t'{ACT_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'h0A01_0909, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'h0AC8_0001, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_ADD, 32'hFFFF_FFFF, 6'd0, 8'hFF, 32'hFFFF_FFFF});
		send_request(route_req_t'{ACT_ADD, 32'h0000_0000, 6'd0, 8'h05, 32'h0000_0005});
		send_request(route_req_t'{ACT_ADD, 32'hFFFF_FFFF, 6'd32, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_CLEAR, 32'h1234_5678, 6'd12, 8'h34, 32'h5678_9ABC});
		send_request(route_req_t'{ACT_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00, 32'h0});
		drain_replies();
		apply_default(1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_request(route_req_t'{ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_ADD, 32'h8000_0000, 6'd1, 8'h7F, 32'h0000_1234});
		send_request(route_req_t'{ACT_LOOKUP, 32'h8000_0001, 6'd0, 8'h00, 32'h0});
		send_request(route_req_t'{ACT_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'h00, 32'h0});

		// Random part in segments, each with its own default route; idling changes every two segments.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_replies();
			case (seg)
				0: apply_default(1'b1, 8'($urandom), $urandom);
				1: apply_default(1'b0, 8'hFF, 32'hFFFF_FFFF);
				2: apply_default(1'b1, 8'h00, 32'h0);
				3: apply_default(1'b1, 8'($urandom), $urandom);
				4: apply_default(1'b0, 8'($urandom), $urandom);
				default: apply_default(1'b1, 8'hFF, 32'hFFFF_FFFF);
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct = 23;
					recv_stall_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (SEGMENT_ITEMS) send_request(random_request());
		end

		// Let the last replies out, then idle before the final check.
		drain_replies();
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (mirror.fault_count == 0 && mirror.awaited_replies.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
